FILE: rtl/sat_pkg.sv
// shared types and codes for the sorted array table
package sat_pkg;

    localparam logic [2:0] K_INSERT   = 3'd0;
    localparam logic [2:0] K_DELETE   = 3'd1;
    localparam logic [2:0] K_RETRIEVE = 3'd2;
    localparam logic [2:0] K_CLEAR    = 3'd3;
    localparam logic [2:0] K_REWIND   = 3'd4;
    localparam logic [2:0] K_NEXT     = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_PAST_END = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] item_value;
    } sat_req_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] out_value;
        logic [5:0]         entry_count;
        logic               is_full;
        logic [1:0]         status;
    } sat_rsp_t;

    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic       wr;
        logic       hit;
    } sat_tok_t;

endpackage

FILE: rtl/sat_cell.sv
// one storage cell of the table with its stage of the request token
module sat_cell
    import sat_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 6,
    parameter int INDEX      = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sat_tok_t                     tok_in,
    input  logic signed [DATA_WIDTH-1:0] val_in,
    input  logic signed [DATA_WIDTH-1:0] dat_in,
    input  logic [CNT_W-1:0]             count,
    input  logic [CNT_W-1:0]             cursor,
    input  logic signed [DATA_WIDTH-1:0] nbr,
    output sat_tok_t                     tok_out,
    output logic signed [DATA_WIDTH-1:0] val_out,
    output logic signed [DATA_WIDTH-1:0] dat_out,
    output logic signed [DATA_WIDTH-1:0] entry
);

    localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

    logic signed [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic signed [DATA_WIDTH-1:0] val_reg, dat_reg, dat_next;
    sat_tok_t                     tok_reg, tok_next;
    logic                         occ, tail, less, same;

    always_comb
    begin
        occ        = POS < count;
        tail       = POS == count;
        less       = entry_reg < val_in;
        same       = entry_reg == val_in;
        entry_next = entry_reg;
        tok_next   = tok_in;
        dat_next   = dat_in;
        if (tok_in.vld)
        begin
            unique case (tok_in.kind)
                K_INSERT:
                begin
                    // first slot not below the value takes it, later slots take the carry
                    if (tok_in.wr && (occ || tail) && (tok_in.hit || !occ || !less))
                    begin
                        entry_next   = tok_in.hit ? dat_in : val_in;
                        dat_next     = entry_reg;
                        tok_next.hit = 1'b1;
                    end
                end
                K_DELETE:
                begin
                    if (occ && (tok_in.hit || same))
                    begin
                        entry_next   = nbr;
                        tok_next.hit = 1'b1;
                    end
                end
                K_RETRIEVE:
                begin
                    if (occ && same)
                    begin
                        tok_next.hit = 1'b1;
                    end
                end
                K_NEXT:
                begin
                    if (occ && POS == cursor)
                    begin
                        dat_next     = entry_reg;
                        tok_next.hit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        val_reg   <= val_in;
        dat_reg   <= dat_next;
    end

    assign tok_out = tok_reg;
    assign val_out = val_reg;
    assign dat_out = dat_reg;
    assign entry   = entry_reg;

endmodule

FILE: rtl/sorted_array_table.sv
// sorted array table: ordered value store built as a row of shifting cells
//
//   channel | valid     | stall     | word
//   request | req_valid | req_stall | req (sat_req_t)
//   result  | rsp_valid | rsp_stall | rsp (sat_rsp_t)
//
// a request passes the launch register, all DEPTH cells, the finish (pending) register
// and the output register, where its result becomes valid
// one request in flight; req_stall is high until its result is in the output register
// reset clears count, cursor and control; cell contents stay undefined
// a stalled result holds the next result back in a pending register
module sorted_array_table
    import sat_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  sat_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output sat_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             cursor_reg, cursor_next;
    sat_tok_t                     ltok_reg, ltok_next;
    logic signed [DATA_WIDTH-1:0] lval_reg, lval_next;
    sat_rsp_t                     pend_reg, pend_next;
    sat_rsp_t                     rsp_reg;
    logic                         rsp_valid_reg;

    sat_tok_t                     tok_w [DEPTH+1];
    logic signed [DATA_WIDTH-1:0] val_w [DEPTH+1];
    logic signed [DATA_WIDTH-1:0] dat_w [DEPTH+1];
    logic signed [DATA_WIDTH-1:0] ent_w [DEPTH+1];
    logic [DEPTH:0]               tok_vld;

    logic req_fire, rsp_free;

    assign req_fire  = req_valid && state_reg == S_IDLE;
    assign req_stall = state_reg != S_IDLE;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        ltok_next = '0;
        lval_next = DATA_WIDTH'(req.item_value);
        if (req_fire)
        begin
            ltok_next.vld  = 1'b1;
            ltok_next.kind = req.kind;
            ltok_next.wr   = count_reg != CNT_W'(DEPTH);
        end
    end

    assign tok_w[0]     = ltok_reg;
    assign val_w[0]     = lval_reg;
    assign dat_w[0]     = '0;
    assign ent_w[DEPTH] = '0;
    assign tok_vld[0]   = ltok_reg.vld;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sat_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_w[i]),
            .val_in  (val_w[i]),
            .dat_in  (dat_w[i]),
            .count   (count_reg),
            .cursor  (cursor_reg),
            .nbr     (ent_w[i+1]),
            .tok_out (tok_w[i+1]),
            .val_out (val_w[i+1]),
            .dat_out (dat_w[i+1]),
            .entry   (ent_w[i])
        );
        assign tok_vld[i+1] = tok_w[i+1].vld;
    end

    // finish: apply count and cursor changes and build the result word
    always_comb
    begin
        sat_tok_t t;
        t           = tok_w[DEPTH];
        count_next  = count_reg;
        cursor_next = cursor_reg;
        pend_next   = '0;
        unique case (t.kind)
            K_INSERT:
            begin
                if (t.wr)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next.status = ST_FULL;
                end
            end
            K_DELETE:
            begin
                if (t.hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next.status = ST_ABSENT;
                end
            end
            K_RETRIEVE:
            begin
                if (t.hit)
                begin
                    pend_next.found     = 1'b1;
                    pend_next.out_value = 32'(val_w[DEPTH]);
                end
            end
            K_CLEAR:
            begin
                count_next = '0;
            end
            K_REWIND:
            begin
                cursor_next = '0;
            end
            K_NEXT:
            begin
                if (t.hit)
                begin
                    pend_next.out_value = 32'(dat_w[DEPTH]);
                    cursor_next         = cursor_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next.status = ST_PAST_END;
                end
            end
            default:
            begin
            end
        endcase
        pend_next.entry_count = 6'(count_next);
        pend_next.is_full     = count_next == CNT_W'(DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            ltok_reg      <= '0;
            lval_reg      <= '0;
            pend_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ltok_reg <= ltok_next;
            lval_reg <= lval_next;
            if (rsp_valid_reg && !rsp_stall && state_reg != S_HOLD)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (tok_w[DEPTH].vld)
                    begin
                        count_reg  <= count_next;
                        cursor_reg <= cursor_next;
                        pend_reg   <= pend_next;
                        state_reg  <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg       <= pend_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell row");

    a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_w[DEPTH].vld |-> state_reg == S_RUN)
        else $error("token left the row outside a run");

    a_state_still: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && !tok_w[DEPTH].vld) |=>
            ($stable(count_reg) && $stable(cursor_reg)))
        else $error("count or cursor moved while a token was in the row");

    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_RUN && ltok_reg.vld))
        else $error("accepted word did not launch a token");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (count_reg <= CNT_W'(DEPTH)))
        else $error("entry count above capacity");

endmodule

FILE: dv/tb.sv
// testbench for sorted_array_table: directed table then random phases, checked by a predictor
`timescale 1ns / 100ps

module tb;
    import sat_pkg::*;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int RAND_WORDS = 2000;
    localparam int CALM_FROM  = 1700;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 150;

    localparam logic [2:0] K_SPARE6 = 3'd6;
    localparam logic [2:0] K_SPARE7 = 3'd7;

    localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

    typedef struct {
        sat_req_t word;
        bit       typed;
        sat_rsp_t want;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    sat_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    sat_rsp_t rsp;

    logic signed [31:0] tbl_vals [DEPTH];
    int                 tbl_count;
    int                 tbl_cursor;

    sat_rsp_t pending_rsp [$];
    dir_row_t dir_rows [$];
    sat_rsp_t want_rsp;
    int       err_cnt   = 0;
    int       accepted  = 0;
    bit       calm      = 1'b0;
    bit       held_long = 1'b0;

    sorted_array_table #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sat_rsp_t table_apply(sat_req_t w);
        sat_rsp_t           r;
        int                 loc;
        int                 i;
        logic signed [31:0] v;
        r   = '0;
        v   = w.item_value;
        loc = 0;
        case (w.kind)
            K_INSERT:
            begin
                if (tbl_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    while (loc < tbl_count && $signed(tbl_vals[loc]) < $signed(v))
                        loc++;
                    for (i = tbl_count; i > loc; i--)
                        tbl_vals[i] = tbl_vals[i - 1];
                    tbl_vals[loc] = v;
                    tbl_count++;
                end
            end
            K_DELETE:
            begin
                while (loc < tbl_count && tbl_vals[loc] != v)
                    loc++;
                if (loc >= tbl_count)
                    r.status = ST_ABSENT;
                else
                begin
                    for (i = loc; i + 1 < tbl_count; i++)
                        tbl_vals[i] = tbl_vals[i + 1];
                    tbl_count--;
                end
            end
            K_RETRIEVE:
            begin
                for (i = 0; i < tbl_count; i++)
                    if (tbl_vals[i] == v)
                        r.found = 1'b1;
                if (r.found)
                    r.out_value = v;
            end
            K_CLEAR:
                tbl_count = 0;
            K_REWIND:
                tbl_cursor = 0;
            K_NEXT:
            begin
                if (tbl_cursor < tbl_count)
                begin
                    r.out_value = tbl_vals[tbl_cursor];
                    tbl_cursor++;
                end
                else
                    r.status = ST_PAST_END;
            end
            default:
                ;
        endcase
        r.entry_count = 6'(tbl_count);
        r.is_full     = (tbl_count == DEPTH);
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return $signed($urandom_range(0, 16)) - 8;
            4:
                case ($urandom_range(0, 3))
                    0: return V_MIN;
                    1: return V_MAX;
                    2: return -1;
                    default: return 0;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    // weights per kind, byte k is kind k, each row sums to 100
    function automatic logic [2:0] pick_kind(int mode);
        logic [63:0] mix;
        int          roll;
        int          k;
        case (mode)
            0: mix = {8'd3, 8'd2, 8'd12, 8'd4, 8'd0, 8'd10, 8'd8, 8'd61};
            1: mix = {8'd3, 8'd2, 8'd14, 8'd4, 8'd2, 8'd15, 8'd50, 8'd10};
            2: mix = {8'd3, 8'd3, 8'd16, 8'd6, 8'd2, 8'd20, 8'd25, 8'd25};
            default: mix = {8'd2, 8'd2, 8'd50, 8'd15, 8'd1, 8'd15, 8'd5, 8'd10};
        endcase
        roll = $urandom_range(0, 99);
        for (k = 0; k < 8; k++)
        begin
            if (roll < int'(mix[8*k +: 8]))
                return 3'(k);
            roll -= int'(mix[8*k +: 8]);
        end
        return K_REWIND;
    endfunction

    task automatic add_row(input logic [2:0] k, input logic signed [31:0] v, input bit typed,
                           input logic fnd, input logic signed [31:0] ov,
                           input logic [5:0] cnt, input logic [1:0] st);
        dir_row_t r;
        r.word.kind        = k;
        r.word.item_value  = v;
        r.typed            = typed;
        r.want.found       = fnd;
        r.want.out_value   = ov;
        r.want.entry_count = cnt;
        r.want.is_full     = 1'b0;
        r.want.status      = st;
        dir_rows.push_back(r);
    endtask

    // offer one word and return once it is taken, at the following falling edge
    task automatic drive_word(input sat_req_t w);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        accepted++;
        @(negedge clk);
    endtask

    initial
    begin
        sat_req_t w;
        sat_rsp_t got;
        int       mode;
        int       n;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        tbl_count  = 0;
        tbl_cursor = 0;
        mode       = 0;

        add_row(K_NEXT,     0,     1, 0, 0,     0, ST_PAST_END);
        add_row(K_RETRIEVE, 5,     1, 0, 0,     0, ST_OK);
        add_row(K_DELETE,   5,     1, 0, 0,     0, ST_ABSENT);
        add_row(K_INSERT,   V_MAX, 1, 0, 0,     1, ST_OK);
        add_row(K_INSERT,   V_MIN, 1, 0, 0,     2, ST_OK);
        add_row(K_INSERT,   0,     0, 0, 0,     0, ST_OK);
        add_row(K_INSERT,   0,     0, 0, 0,     0, ST_OK);
        add_row(K_INSERT,   -1,    0, 0, 0,     0, ST_OK);
        add_row(K_RETRIEVE, V_MIN, 1, 1, V_MIN, 5, ST_OK);
        add_row(K_RETRIEVE, V_MAX, 1, 1, V_MAX, 5, ST_OK);
        add_row(K_RETRIEVE, 7,     0, 0, 0,     0, ST_OK);
        add_row(K_REWIND,   0,     1, 0, 0,     5, ST_OK);
        add_row(K_NEXT,     0,     1, 0, V_MIN, 5, ST_OK);
        add_row(K_NEXT,     0,     0, 0, 0,     0, ST_OK);
        add_row(K_NEXT,     0,     0, 0, 0,     0, ST_OK);
        add_row(K_NEXT,     0,     0, 0, 0,     0, ST_OK);
        add_row(K_NEXT,     0,     1, 0, V_MAX, 5, ST_OK);
        add_row(K_NEXT,     0,     1, 0, 0,     5, ST_PAST_END);
        add_row(K_DELETE,   0,     0, 0, 0,     0, ST_OK);
        add_row(K_DELETE,   123,   1, 0, 0,     4, ST_ABSENT);
        add_row(K_SPARE6,   -1,    0, 0, 0,     0, ST_OK);
        add_row(K_SPARE7,   V_MIN, 0, 0, 0,     0, ST_OK);
        add_row(K_CLEAR,    0,     1, 0, 0,     0, ST_OK);
        add_row(K_NEXT,     0,     1, 0, 0,     0, ST_PAST_END);
        add_row(K_REWIND,   0,     0, 0, 0,     0, ST_OK);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            drive_word(dir_rows[i].word);
            got = table_apply(dir_rows[i].word);
            pending_rsp.push_back(dir_rows[i].typed ? dir_rows[i].want : got);
        end

        for (n = 0; n < RAND_WORDS; n++)
        begin
            if (n % 150 == 0)
                mode = $urandom_range(0, 3);
            calm   = (n >= CALM_FROM);
            w.kind = pick_kind(mode);
            if ((w.kind == K_DELETE || w.kind == K_RETRIEVE) && tbl_count > 0 &&
                $urandom_range(0, 9) < 6)
                w.item_value = tbl_vals[$urandom_range(0, tbl_count - 1)];
            else
                w.item_value = pick_value();
            drive_word(w);
            pending_rsp.push_back(table_apply(w));
        end
        req_valid <= 1'b0;

        wait (pending_rsp.size() == 0);
        repeat (DEPTH + 8) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver side stall, with one long hold-off to back the block up
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_long && accepted >= HOLD_AT)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                rsp_stall <= 1'b0;
                held_long = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result word: found=%0b value=%0d count=%0d full=%0b status=%0d",
                             rsp.found, rsp.out_value, rsp.entry_count, rsp.is_full, rsp.status);
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp.found !== want_rsp.found || rsp.out_value !== want_rsp.out_value ||
                    rsp.entry_count !== want_rsp.entry_count ||
                    rsp.is_full !== want_rsp.is_full || rsp.status !== want_rsp.status)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("mismatch exp: found=%0b value=%0d count=%0d full=%0b status=%0d",
                                 want_rsp.found, want_rsp.out_value, want_rsp.entry_count,
                                 want_rsp.is_full, want_rsp.status);
                        $display("         got: found=%0b value=%0d count=%0d full=%0b status=%0d",
                                 rsp.found, rsp.out_value, rsp.entry_count, rsp.is_full,
                                 rsp.status);
                    end
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
